// ===== src/ddg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day number to Gregorian date: shared definitions
// Cycle lengths, the valid range, the sideband record that travels with each
// request through the divider chain, and the month start table.
// ----------------------------------------------------------------------------
package ddg_pkg;

  localparam logic [21:0] LAST_VALID_DN = 22'd3652059;

  localparam int CYC400 = 146097;
  localparam int CYC100 = 36524;
  localparam int CYC4   = 1461;
  localparam int CYC1   = 365;

  // Quotient of the 4-year division that marks the last 4-year cycle of a century.
  localparam logic [4:0] Q4_LAST_IN_CENTURY = 5'd24;
  // Quotient of the 100-year division that marks the century ending a 400-year cycle.
  localparam logic [1:0] Q100_LAST = 2'd3;
  // Quotient of the 1-year division that marks the leap year of a 4-year cycle.
  localparam logic [1:0] Q1_LAST = 2'd3;

  typedef struct packed {
    logic       ok;
    logic [4:0] q400;
    logic [1:0] q100;
    logic [4:0] q4;
  } side_t;

  // Day of year (from 0) on which month mon_idx (0 = January) begins.
  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] mon_idx);
    logic [8:0] base;
    case (mon_idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon_idx >= 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

// ===== src/ddg_divc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Constant divider stage group
// Three-stage pipelined division by a constant: reciprocal estimate, remainder,
// and a single correction step, with an optional fold of quotient four.
// ----------------------------------------------------------------------------
module ddg_divc #(
  parameter int W       = 22,
  parameter int Divisor = 146097,
  parameter int QW      = 5,
  parameter int RW      = 18,
  parameter bit Fold    = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  ddg_pkg::side_t       in_side,
  input  logic [W-1:0]         in_num,
  output logic                 out_vld,
  output ddg_pkg::side_t       out_side,
  output logic [QW-1:0]        out_quo,
  output logic [RW-1:0]        out_rem
);

  // The reciprocal is scaled by 2**W, so the estimate is at most one low.
  localparam int Recip = (1 << W) / Divisor;
  localparam int RecW  = $clog2(Recip + 1);
  localparam int PW    = W + RecW;
  localparam logic [RecW-1:0] RecipC = RecW'(Recip);
  localparam logic [RW:0]     DivC   = (RW + 1)'(Divisor);

  logic [PW-1:0]  prod;
  logic           a_vld_r;
  ddg_pkg::side_t a_side_r;
  logic [W-1:0]   a_num_r;
  logic [QW-1:0]  a_quo_r;

  logic [W-1:0]   b_mul;
  logic [RW:0]    b_rem_nxt;
  logic           b_vld_r;
  ddg_pkg::side_t b_side_r;
  logic [QW-1:0]  b_quo_r;
  logic [RW:0]    b_rem_r;

  logic [QW-1:0]  c_quo_nxt;
  logic [RW:0]    c_rem_nxt;
  logic           c_vld_r;
  ddg_pkg::side_t c_side_r;
  logic [QW-1:0]  c_quo_r;
  logic [RW-1:0]  c_rem_r;

  assign prod      = PW'(in_num) * PW'(RecipC);
  assign b_mul     = W'(a_quo_r) * W'(Divisor);
  assign b_rem_nxt = (RW + 1)'(a_num_r - b_mul);

  always_comb begin
    c_quo_nxt = b_quo_r;
    c_rem_nxt = b_rem_r;
    if (b_rem_r >= DivC) begin
      c_quo_nxt = b_quo_r + QW'(1);
      c_rem_nxt = b_rem_r - DivC;
    end
    // A quotient of four only occurs on the last day of the outer cycle.
    if (Fold && (c_quo_nxt == QW'(4))) begin
      c_quo_nxt = QW'(3);
      c_rem_nxt = c_rem_nxt + DivC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    a_side_r <= in_side;
    a_num_r  <= in_num;
    a_quo_r  <= QW'(prod[PW-1:W]);
    b_side_r <= a_side_r;
    b_quo_r  <= a_quo_r;
    b_rem_r  <= b_rem_nxt;
    c_side_r <= b_side_r;
    c_quo_r  <= c_quo_nxt;
    c_rem_r  <= RW'(c_rem_nxt);
  end

  assign out_vld  = c_vld_r;
  assign out_side = c_side_r;
  assign out_quo  = c_quo_r;
  assign out_rem  = c_rem_r;

endmodule

// ===== src/ddg_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date assembly stages
// Rebuilds the year from the cycle quotients, finds the month from the day of
// year and registers the final date, zeroed for rejected requests.
// ----------------------------------------------------------------------------
module ddg_date (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  ddg_pkg::side_t in_side,
  input  logic [1:0]     in_q1,
  input  logic [8:0]     in_doy,
  output logic           out_strobe,
  output logic           out_valid_res,
  output logic [13:0]    out_year,
  output logic [3:0]     out_month,
  output logic [4:0]     out_day_of_month
);

  logic [13:0] year_nxt;
  logic        leap_nxt;
  logic        y_vld_r;
  logic        y_ok_r;
  logic [13:0] y_year_r;
  logic        y_leap_r;
  logic [8:0]  y_doy_r;

  logic [3:0]  mon_nxt;
  logic        m_vld_r;
  logic        m_ok_r;
  logic [13:0] m_year_r;
  logic        m_leap_r;
  logic [8:0]  m_doy_r;
  logic [3:0]  m_mon_r;

  logic [4:0]  dom_nxt;
  logic        o_vld_r;
  logic        o_ok_r;
  logic [13:0] o_year_r;
  logic [3:0]  o_mon_r;
  logic [4:0]  o_dom_r;

  assign year_nxt = 14'd1 + (14'(in_side.q400) * 14'd400) + (14'(in_side.q100) * 14'd100)
                  + {7'd0, in_side.q4, 2'b00} + 14'(in_q1);

  // Leap when the year closes a 4-year cycle, unless it closes a century
  // that does not also close the 400-year cycle.
  assign leap_nxt = (in_q1 == ddg_pkg::Q1_LAST)
                 && ((in_side.q4 != ddg_pkg::Q4_LAST_IN_CENTURY)
                     || (in_side.q100 == ddg_pkg::Q100_LAST));

  always_comb begin
    mon_nxt = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (y_doy_r >= ddg_pkg::month_start(y_leap_r, 4'(k))) begin
        mon_nxt = mon_nxt + 4'd1;
      end
    end
  end

  assign dom_nxt = 5'(m_doy_r - ddg_pkg::month_start(m_leap_r, m_mon_r - 4'd1) + 9'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r <= 1'b0;
      m_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      y_vld_r <= in_vld;
      m_vld_r <= y_vld_r;
      o_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    y_ok_r   <= in_side.ok;
    y_year_r <= year_nxt;
    y_leap_r <= leap_nxt;
    y_doy_r  <= in_doy;
    m_ok_r   <= y_ok_r;
    m_year_r <= y_year_r;
    m_leap_r <= y_leap_r;
    m_doy_r  <= y_doy_r;
    m_mon_r  <= mon_nxt;
    o_ok_r   <= m_ok_r;
    o_year_r <= m_ok_r ? m_year_r : 14'd0;
    o_mon_r  <= m_ok_r ? m_mon_r : 4'd0;
    o_dom_r  <= m_ok_r ? dom_nxt : 5'd0;
  end

  assign out_strobe       = o_vld_r;
  assign out_valid_res    = o_ok_r;
  assign out_year         = o_year_r;
  assign out_month        = o_mon_r;
  assign out_day_of_month = o_dom_r;

  a_valid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res) |-> ((out_year >= 14'd1) && (out_year <= 14'd9999)
      && (out_month >= 4'd1) && (out_month <= 4'd12)
      && (out_day_of_month >= 5'd1) && (out_day_of_month <= 5'd31)))
    else $error("valid date out of range");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |-> ((out_year == 14'd0) && (out_month == 4'd0)
      && (out_day_of_month == 5'd0)))
    else $error("rejected request carries a nonzero date");

  a_february: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res && (out_month == 4'd2)) |-> (out_day_of_month <= 5'd29))
    else $error("February day past 29");

endmodule

// ===== src/day_number_to_gregorian_date.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day number to Gregorian date converter
// Converts a proleptic Gregorian day number (day 1 is 0001-01-01) into year,
// month and day of month, flagging numbers outside 1..3652059 as invalid.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Handshake
//  -------   -------------------------------------   ------------------------
//  request   start, busy, in_day_number              taken when start & !busy
//  result    out_strobe, out_valid_res, out_year,    one cycle, marked by
//            out_month, out_day_of_month             out_strobe, no back-pressure
//
// A request may be issued on every clock cycle outside reset; each one
// produces exactly one result, in order. The pipeline is made of the
// four constant divisions (400-, 100-, 4- and 1-year cycles), each a
// three-stage group of reciprocal multiply, remainder and correction, plus
// one input stage and three date stages (year, month, day).
// busy is high only while rst_n is low; the synchronous reset clears all
// valid bits, so no result appears until a request is taken after reset.
// The receiver cannot stall, so the pipeline never stops.
//
// Invalid requests (day number zero or past 9999-12-31) travel through the
// pipeline with a cleared ok flag and come out with all date fields zero.
// The last day of a 400-year cycle and of a 4-year cycle are folded back so
// that they land on December 31 of the preceding leap year.
//
module day_number_to_gregorian_date (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [21:0] in_day_number,
  output logic        out_strobe,
  output logic        out_valid_res,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month
);

  localparam int Latency = 16;

  logic           in_ok;
  logic [21:0]    t0_nxt;
  logic           s0_vld_r;
  ddg_pkg::side_t s0_side_r;
  ddg_pkg::side_t s0_side_nxt;
  logic [21:0]    s0_t_r;

  logic           d400_vld;
  ddg_pkg::side_t d400_side;
  logic [4:0]     d400_quo;
  logic [17:0]    d400_rem;
  ddg_pkg::side_t d100_side_in;

  logic           d100_vld;
  ddg_pkg::side_t d100_side;
  logic [2:0]     d100_quo;
  logic [15:0]    d100_rem;
  ddg_pkg::side_t d4_side_in;

  logic           d4_vld;
  ddg_pkg::side_t d4_side;
  logic [4:0]     d4_quo;
  logic [10:0]    d4_rem;
  ddg_pkg::side_t d1_side_in;

  logic           d1_vld;
  ddg_pkg::side_t d1_side;
  logic [2:0]     d1_quo;
  logic [8:0]     d1_rem;

  // The pipeline takes a new request on every cycle outside reset.
  assign busy = ~rst_n;

  assign in_ok  = (in_day_number != 22'd0) && (in_day_number <= ddg_pkg::LAST_VALID_DN);
  // Rejected requests enter with zero so the dividers stay in their range.
  assign t0_nxt = in_ok ? (in_day_number - 22'd1) : 22'd0;

  always_comb begin
    s0_side_nxt      = '0;
    s0_side_nxt.ok   = in_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_side_r <= s0_side_nxt;
    s0_t_r    <= t0_nxt;
  end

  // 400-year cycles: quotient 0..24, remainder below 146097.
  ddg_divc #(
    .W       (22),
    .Divisor (ddg_pkg::CYC400),
    .QW      (5),
    .RW      (18),
    .Fold    (1'b0)
  ) u_div400 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s0_vld_r),
    .in_side  (s0_side_r),
    .in_num   (s0_t_r),
    .out_vld  (d400_vld),
    .out_side (d400_side),
    .out_quo  (d400_quo),
    .out_rem  (d400_rem)
  );

  always_comb begin
    d100_side_in      = d400_side;
    d100_side_in.q400 = d400_quo;
  end

  // Centuries: the last day of a 400-year cycle folds into the fourth century.
  ddg_divc #(
    .W       (18),
    .Divisor (ddg_pkg::CYC100),
    .QW      (3),
    .RW      (16),
    .Fold    (1'b1)
  ) u_div100 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d400_vld),
    .in_side  (d100_side_in),
    .in_num   (d400_rem),
    .out_vld  (d100_vld),
    .out_side (d100_side),
    .out_quo  (d100_quo),
    .out_rem  (d100_rem)
  );

  always_comb begin
    d4_side_in      = d100_side;
    d4_side_in.q100 = d100_quo[1:0];
  end

  // 4-year cycles within a century: quotient 0..24.
  ddg_divc #(
    .W       (16),
    .Divisor (ddg_pkg::CYC4),
    .QW      (5),
    .RW      (11),
    .Fold    (1'b0)
  ) u_div4 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d100_vld),
    .in_side  (d4_side_in),
    .in_num   (d100_rem),
    .out_vld  (d4_vld),
    .out_side (d4_side),
    .out_quo  (d4_quo),
    .out_rem  (d4_rem)
  );

  always_comb begin
    d1_side_in    = d4_side;
    d1_side_in.q4 = d4_quo;
  end

  // Single years: the leap day of a 4-year cycle folds into the fourth year.
  ddg_divc #(
    .W       (11),
    .Divisor (ddg_pkg::CYC1),
    .QW      (3),
    .RW      (9),
    .Fold    (1'b1)
  ) u_div1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (d4_vld),
    .in_side  (d1_side_in),
    .in_num   (d4_rem),
    .out_vld  (d1_vld),
    .out_side (d1_side),
    .out_quo  (d1_quo),
    .out_rem  (d1_rem)
  );

  ddg_date u_date (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (d1_vld),
    .in_side          (d1_side),
    .in_q1            (d1_quo[1:0]),
    .in_doy           (d1_rem),
    .out_strobe       (out_strobe),
    .out_valid_res    (out_valid_res),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month)
  );

  a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency out_strobe)
    else $error("request without a result at the expected latency");

  a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, Latency))
    else $error("result without a matching request");

  a_valid_matches_range: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##Latency (out_valid_res == $past(in_ok, Latency)))
    else $error("validity flag does not match the request range");

endmodule
